### src/swf_pkg.sv
package swf_pkg;

  // fixed field widths of the channels
  localparam int WORD_W = 32;
  localparam int POS_W  = 4;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [POS_W-1:0]  pos_t;

  // word kinds on the input channel
  typedef enum logic {
    KIND_WEIGHT = 1'b0,
    KIND_DRAIN  = 1'b1
  } kind_e;

  // per-word result flags handed from control to the pipeline
  typedef struct packed {
    logic fwd_valid;
    logic pe_valid;
    logic pe_last;
    logic busy;
  } res_ctl_t;

endpackage

### src/swf_if.sv
// input words: chain weights and drain requests
interface swf_in_if;
  import swf_pkg::*;
  logic  valid;
  logic  ready;
  logic  kind;
  word_t weight_word;

  modport source (output valid, output kind, output weight_word, input ready);
  modport sink   (input valid, input kind, input weight_word, output ready);
endinterface

// result words
interface swf_out_if;
  import swf_pkg::*;
  logic  valid;
  logic  ready;
  logic  forward_valid;
  word_t forward_word;
  logic  pe_valid;
  word_t pe_word;
  logic  pe_last;
  logic  busy_res;

  modport source (
    output valid, output forward_valid, output forward_word, output pe_valid,
    output pe_word, output pe_last, output busy_res, input ready
  );
  modport sink (
    input valid, input forward_valid, input forward_word, input pe_valid,
    input pe_word, input pe_last, input busy_res, output ready
  );
endinterface

// feeder position register write
interface swf_cfg_if;
  import swf_pkg::*;
  logic valid;
  logic ready;
  pos_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/systolic_weight_feeder_pingpong_unit.sv
// path: an accepted word waits in stage one while the output register is blocked, then moves into it
// throughput: one word per cycle while the result port is ready, weights and drain requests alike
// the bank memory read is registered in the first stage, the second is the output register
// reset clears counters, bank full flags, write bank select, position and pipeline valids
// bank memory contents are not cleared and need writing before they are drained
module systolic_weight_feeder_pingpong_unit #(
  parameter int COLUMNS    = 8,
  parameter int OUT_BLOCK  = 4,
  parameter int IN_BLOCK   = 4,
  parameter int REPEAT     = 4,
  parameter int WORD_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  swf_in_if.sink       in_i,
  swf_cfg_if.sink      cfg_i,
  swf_out_if.source    res_o
);
  import swf_pkg::*;

  localparam int BANK_WORDS = OUT_BLOCK * IN_BLOCK;
  localparam int IDX_W = (BANK_WORDS > 1) ? $clog2(BANK_WORDS) : 1;
  localparam int SW    = (WORD_WIDTH < WORD_W) ? WORD_WIDTH : WORD_W;

  pos_t           pos_q;
  logic           in_ready;
  logic           acc;
  res_ctl_t       ctl;
  logic           mem_we;
  logic           mem_re;
  logic [IDX_W:0] mem_waddr;
  logic [IDX_W:0] mem_raddr;
  logic [SW-1:0]  wdata;
  logic [SW-1:0]  rdata;

  logic           s1_valid_q;
  res_ctl_t       s1_ctl_q;
  logic [SW-1:0]  s1_word_q;
  logic           s1_move;

  logic           out_valid_q;
  res_ctl_t       out_ctl_q;
  word_t          out_fwd_word_q;
  word_t          out_pe_word_q;

  // position register, always writable
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (cfg_i.valid) begin
      pos_q <= cfg_i.data;
    end
  end

  // handshake: stage one frees when it moves to the output register
  assign s1_move  = s1_valid_q && (!out_valid_q || res_o.ready);
  assign in_ready = !s1_valid_q || s1_move;
  assign in_i.ready = in_ready;
  assign acc      = in_i.valid && in_ready;
  assign wdata    = in_i.weight_word[SW-1:0];

  swf_ctrl #(
    .COLUMNS   (COLUMNS),
    .OUT_BLOCK (OUT_BLOCK),
    .IN_BLOCK  (IN_BLOCK),
    .REPEAT    (REPEAT),
    .IDX_W     (IDX_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .kind_i      (in_i.kind),
    .pos_i       (pos_q),
    .ctl_o       (ctl),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr)
  );

  swf_bank #(
    .DATA_W (SW),
    .ADDR_W (IDX_W + 1)
  ) u_bank (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rdata)
  );

  // pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // stage one and output payload
  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_ctl_q  <= ctl;
      s1_word_q <= wdata;
    end
    if (s1_move) begin
      out_ctl_q      <= s1_ctl_q;
      out_fwd_word_q <= s1_ctl_q.fwd_valid ? WORD_W'(s1_word_q) : '0;
      out_pe_word_q  <= s1_ctl_q.pe_valid ? WORD_W'(rdata) : '0;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.forward_valid = out_ctl_q.fwd_valid;
  assign res_o.forward_word  = out_fwd_word_q;
  assign res_o.pe_valid      = out_ctl_q.pe_valid;
  assign res_o.pe_word       = out_pe_word_q;
  assign res_o.pe_last       = out_ctl_q.pe_last;
  assign res_o.busy_res      = out_ctl_q.busy;

  // input stalls only when both stages hold a word and the output is blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> (s1_valid_q && out_valid_q && !res_o.ready))
    else $error("input stalled with room in the pipeline");

  // every accepted word lands in stage one
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> s1_valid_q)
    else $error("accepted word lost before stage one");

  // a word leaving stage one always reaches the output register
  a_move_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move |=> out_valid_q)
    else $error("stage one word lost before output");

endmodule

### src/swf_bank.sv
module swf_bank #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 5
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/swf_ctrl.sv
module swf_ctrl #(
  parameter int COLUMNS   = 8,
  parameter int OUT_BLOCK = 4,
  parameter int IN_BLOCK  = 4,
  parameter int REPEAT    = 4,
  parameter int IDX_W     = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             acc_i,
  input  logic             kind_i,
  input  swf_pkg::pos_t    pos_i,
  output swf_pkg::res_ctl_t ctl_o,
  output logic             mem_we_o,
  output logic [IDX_W:0]   mem_waddr_o,
  output logic             mem_re_o,
  output logic [IDX_W:0]   mem_raddr_o
);
  import swf_pkg::*;

  localparam int BANK_WORDS = OUT_BLOCK * IN_BLOCK;
  localparam int S_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int O_W = (OUT_BLOCK > 1) ? $clog2(OUT_BLOCK) : 1;
  localparam int R_W = (REPEAT > 1) ? $clog2(REPEAT) : 1;
  localparam int I_W = (IN_BLOCK > 1) ? $clog2(IN_BLOCK) : 1;

  logic [IDX_W-1:0] wr_idx_q, wr_idx_d;
  logic [S_W-1:0]   wr_slice_q, wr_slice_d;
  logic [O_W-1:0]   rd_o_q, rd_o_d;
  logic [R_W-1:0]   rd_r_q, rd_r_d;
  logic [I_W-1:0]   rd_i_q, rd_i_d;
  logic             wsel_q, wsel_d;
  logic [1:0]       full_q, full_d;

  logic             wr_last;
  logic             rd_last;
  logic             rsel;
  logic [IDX_W-1:0] rd_idx;

  // block and drain sequence ends
  assign wr_last = (wr_idx_q == IDX_W'(BANK_WORDS - 1)) && (wr_slice_q == S_W'(COLUMNS - 1));
  assign rd_last = (rd_o_q == O_W'(OUT_BLOCK - 1)) && (rd_r_q == R_W'(REPEAT - 1))
                   && (rd_i_q == I_W'(IN_BLOCK - 1));

  // older full bank drains first
  assign rsel   = (full_q == 2'b11) ? wsel_q : ~full_q[0];
  assign rd_idx = IDX_W'(rd_o_q * IN_BLOCK + rd_i_q);

  assign mem_waddr_o = {wsel_q, wr_idx_q};
  assign mem_raddr_o = {rsel, rd_idx};

  // per-word decisions and counter advance
  always_comb begin
    wr_idx_d   = wr_idx_q;
    wr_slice_d = wr_slice_q;
    rd_o_d     = rd_o_q;
    rd_r_d     = rd_r_q;
    rd_i_d     = rd_i_q;
    wsel_d     = wsel_q;
    full_d     = full_q;
    ctl_o      = '0;
    mem_we_o   = 1'b0;
    mem_re_o   = 1'b0;
    if (acc_i) begin
      if (kind_i == KIND_WEIGHT) begin
        if (full_q[wsel_q]) begin
          ctl_o.busy = 1'b1;
        end else begin
          mem_we_o        = (pos_i == POS_W'(wr_slice_q));
          ctl_o.fwd_valid = ({1'b0, pos_i} < (POS_W + 1)'(COLUMNS - 1));
          if (wr_idx_q == IDX_W'(BANK_WORDS - 1)) begin
            wr_idx_d = '0;
            if (wr_last) begin
              wr_slice_d     = '0;
              full_d[wsel_q] = 1'b1;
              wsel_d         = ~wsel_q;
            end else begin
              wr_slice_d = wr_slice_q + S_W'(1);
            end
          end else begin
            wr_idx_d = wr_idx_q + IDX_W'(1);
          end
        end
      end else if (full_q != 2'b00) begin
        mem_re_o       = 1'b1;
        ctl_o.pe_valid = 1'b1;
        ctl_o.pe_last  = rd_last;
        if (rd_last) begin
          full_d[rsel] = 1'b0;
        end
        // out-row inner, repeat middle, in-column outer
        if (rd_o_q == O_W'(OUT_BLOCK - 1)) begin
          rd_o_d = '0;
          if (rd_r_q == R_W'(REPEAT - 1)) begin
            rd_r_d = '0;
            if (rd_i_q == I_W'(IN_BLOCK - 1)) begin
              rd_i_d = '0;
            end else begin
              rd_i_d = rd_i_q + I_W'(1);
            end
          end else begin
            rd_r_d = rd_r_q + R_W'(1);
          end
        end else begin
          rd_o_d = rd_o_q + O_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q   <= '0;
      wr_slice_q <= '0;
      rd_o_q     <= '0;
      rd_r_q     <= '0;
      rd_i_q     <= '0;
      wsel_q     <= 1'b0;
      full_q     <= 2'b00;
    end else begin
      wr_idx_q   <= wr_idx_d;
      wr_slice_q <= wr_slice_d;
      rd_o_q     <= rd_o_d;
      rd_r_q     <= rd_r_d;
      rd_i_q     <= rd_i_d;
      wsel_q     <= wsel_d;
      full_q     <= full_d;
    end
  end

  // a drain in progress always has a full bank behind it
  a_drain_has_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((rd_o_q != '0) || (rd_r_q != '0) || (rd_i_q != '0)) |-> (full_q != 2'b00))
    else $error("drain position moved with no full bank");

  // a completed block hands the other bank to the writer
  a_bank_swap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && (kind_i == KIND_WEIGHT) && !full_q[wsel_q] && wr_last)
      |=> (wsel_q != $past(wsel_q)) && full_q[$past(wsel_q)])
    else $error("bank did not swap after a full block");

  // write position stays inside the bank
  a_wr_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_idx_q <= IDX_W'(BANK_WORDS - 1))
    else $error("write index beyond bank size");

endmodule

### tb/sv/tb_systolic_weight_feeder_pingpong_unit.sv
`timescale 1ns / 1ps

module tb_systolic_weight_feeder_pingpong_unit;
  import swf_pkg::*;

  localparam int COLUMNS     = 8;
  localparam int OUT_BLOCK   = 4;
  localparam int IN_BLOCK    = 4;
  localparam int REPEAT      = 4;
  localparam int WORD_WIDTH  = 32;
  localparam int BANK_WORDS  = OUT_BLOCK * IN_BLOCK;
  localparam int BLOCK_WORDS = COLUMNS * BANK_WORDS;
  localparam int DRAIN_WORDS = IN_BLOCK * REPEAT * OUT_BLOCK;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEM_TARGET = 1250;

  typedef struct packed {
    logic  fwd_valid;
    word_t fwd_word;
    logic  pe_valid;
    word_t pe_word;
    logic  pe_last;
    logic  busy;
  } feeder_res_t;

  typedef enum int {
    SINK_OPEN,
    SINK_RANDOM,
    SINK_PERIODIC,
    SINK_SPARSE
  } sink_mode_e;

  // predicted feeder state and the results still owed by the block
  class feeder_scoreboard;
    word_t       bank_mem [2*BANK_WORDS];
    bit          written  [2*BANK_WORDS];
    int unsigned wr_cnt;
    int unsigned rd_cnt;
    bit          wr_sel;
    bit [1:0]    full;
    pos_t        position;
    feeder_res_t expected_results [$];
    int          errors;
    int          checked;

    function new();
      wr_cnt   = 0;
      rd_cnt   = 0;
      wr_sel   = 1'b0;
      full     = 2'b00;
      position = '0;
      errors   = 0;
      checked  = 0;
      foreach (written[i]) written[i] = 1'b0;
      foreach (bank_mem[i]) bank_mem[i] = '0;
    endfunction

    function bit all_written();
      foreach (written[i]) if (!written[i]) return 1'b0;
      return 1'b1;
    endfunction

    // advance the feeder by one word and return what it answers
    function feeder_res_t next_feeder_result(kind_e k, word_t w);
      feeder_res_t r;
      int unsigned slice;
      int unsigned idx;
      int unsigned o1;
      int unsigned i1;
      bit          rb;
      r = '0;
      if (k == KIND_WEIGHT) begin
        // write bank still full: refuse the word
        if (full[wr_sel]) begin
          r.busy = 1'b1;
          return r;
        end
        slice = wr_cnt / BANK_WORDS;
        idx   = wr_cnt % BANK_WORDS;
        if (slice == position) begin
          bank_mem[wr_sel*BANK_WORDS + idx] = w;
          written[wr_sel*BANK_WORDS + idx]  = 1'b1;
        end
        if (position < COLUMNS - 1) begin
          r.fwd_valid = 1'b1;
          r.fwd_word  = w;
        end
        wr_cnt++;
        if (wr_cnt >= BLOCK_WORDS) begin
          wr_cnt       = 0;
          full[wr_sel] = 1'b1;
          wr_sel       = ~wr_sel;
        end
      end else if (full != 2'b00) begin
        // oldest full bank drains: in-column outer, repeat, out-row inner
        if (full == 2'b11) rb = wr_sel;
        else rb = full[0] ? 1'b0 : 1'b1;
        o1  = rd_cnt % OUT_BLOCK;
        i1  = (rd_cnt / (OUT_BLOCK * REPEAT)) % IN_BLOCK;
        idx = o1 * IN_BLOCK + i1;
        r.pe_valid = 1'b1;
        r.pe_word  = bank_mem[rb*BANK_WORDS + idx];
        rd_cnt++;
        if (rd_cnt >= DRAIN_WORDS) begin
          r.pe_last = 1'b1;
          rd_cnt    = 0;
          full[rb]  = 1'b0;
        end
      end
      return r;
    endfunction

    function void note_word(kind_e k, word_t w);
      expected_results.push_back(next_feeder_result(k, w));
    endfunction

    task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch on result %0d: %s got %h want %h", checked, field, got, want);
      errors++;
    endtask

    task check_result(feeder_res_t got);
      feeder_res_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected word", got.pe_word, '0);
      end else begin
        want = expected_results.pop_front();
        if (got.fwd_valid !== want.fwd_valid)
          report_mismatch("forward_valid", got.fwd_valid, want.fwd_valid);
        if (got.fwd_word !== want.fwd_word)
          report_mismatch("forward_word", got.fwd_word, want.fwd_word);
        if (got.pe_valid !== want.pe_valid)
          report_mismatch("pe_valid", got.pe_valid, want.pe_valid);
        if (got.pe_word !== want.pe_word)
          report_mismatch("pe_word", got.pe_word, want.pe_word);
        if (got.pe_last !== want.pe_last)
          report_mismatch("pe_last", got.pe_last, want.pe_last);
        if (got.busy !== want.busy)
          report_mismatch("busy_res", got.busy, want.busy);
      end
      checked++;
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  swf_in_if  in_if ();
  swf_out_if res_if ();
  swf_cfg_if cfg_if ();

  systolic_weight_feeder_pingpong_unit #(
    .COLUMNS   (COLUMNS),
    .OUT_BLOCK (OUT_BLOCK),
    .IN_BLOCK  (IN_BLOCK),
    .REPEAT    (REPEAT),
    .WORD_WIDTH(WORD_WIDTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .cfg_i (cfg_if),
    .res_o (res_if)
  );

  feeder_scoreboard sb;
  feeder_scoreboard plan;
  feeder_res_t      seen;
  int               burst_left;
  bit               gaps_on;
  bit               hold_off_req;
  int               items_sent;
  pos_t             pos_plan [0:5] = '{4'd0, 4'd3, 4'd7, 4'd15, 4'd8, 4'd12};

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #(5_000_000);
    $display("[systolic_weight_feeder_pingpong_unit] ERROR");
    $finish;
  end

  // watch all three channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) sb.position = cfg_if.data;
      if (in_if.valid && in_if.ready) sb.note_word(kind_e'(in_if.kind), in_if.weight_word);
      if (res_if.valid && res_if.ready) begin
        seen.fwd_valid = res_if.forward_valid;
        seen.fwd_word  = res_if.forward_word;
        seen.pe_valid  = res_if.pe_valid;
        seen.pe_word   = res_if.pe_word;
        seen.pe_last   = res_if.pe_last;
        seen.busy      = res_if.busy_res;
        sb.check_result(seen);
      end
    end
  end

  // result sink: stall pattern of its own, plus one long hold-off on request
  initial begin : result_sink
    sink_mode_e mode;
    int         mode_left;
    int         held;
    int         tick;
    res_if.ready <= 1'b0;
    mode      = SINK_OPEN;
    mode_left = 0;
    held      = 0;
    tick      = 0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (hold_off_req) begin
        res_if.ready <= 1'b0;
        held++;
        if (held >= HOLD_CYCLES) begin
          hold_off_req = 1'b0;
          held         = 0;
        end
      end else begin
        if (mode_left == 0) begin
          mode      = sink_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          SINK_OPEN:     res_if.ready <= 1'b1;
          SINK_RANDOM:   res_if.ready <= ($urandom_range(0, 9) < 7);
          SINK_PERIODIC: res_if.ready <= ((tick % 4) != 0);
          default:       res_if.ready <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  function automatic word_t rand_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return word_t'($urandom);
    endcase
  endfunction

  // offer one word in bursts, with random gaps before a burst when gaps_on is set; returns at its accepting edge
  task automatic offer(input kind_e k, input word_t w);
    int gap;
    void'(plan.next_feeder_result(k, w));
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        gap = $urandom_range(1, 6);
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid       <= 1'b1;
    in_if.kind        <= k;
    in_if.weight_word <= w;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    items_sent++;
  endtask

  // stop sending and wait until every word has come back
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (sb.checked < items_sent) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // stimulus
  initial begin : stimulus
    int   phase;
    int   nblocks;
    int   n;
    int   drain_pct;
    pos_t new_pos;
    sb   = new();
    plan = new();
    burst_left   = 0;
    gaps_on      = 1'b0;
    hold_off_req = 1'b0;
    items_sent   = 0;
    rst_ni            <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.kind        <= KIND_WEIGHT;
    in_if.weight_word <= '0;
    cfg_if.valid      <= 1'b0;
    cfg_if.data       <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: drains with no bank full, extreme and striped words
    offer(KIND_DRAIN, '0);
    offer(KIND_WEIGHT, '0);
    offer(KIND_WEIGHT, '1);
    offer(KIND_WEIGHT, 32'hAAAA_AAAA);
    offer(KIND_WEIGHT, 32'h5555_5555);
    offer(KIND_DRAIN, '1);
    offer(KIND_WEIGHT, 32'h0000_0001);
    offer(KIND_WEIGHT, 32'h8000_0000);
    offer(KIND_DRAIN, 32'h1234_5678);
    offer(KIND_WEIGHT, 32'hFFFF_0000);
    offer(KIND_WEIGHT, 32'h0000_FFFF);
    offer(KIND_DRAIN, '0);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      wait_drained();

      // new position; before both banks are known written, only at a block start
      new_pos = (phase < 6) ? pos_plan[phase] : pos_t'($urandom_range(0, 15));
      if (new_pos == plan.position || plan.all_written() ||
          (plan.wr_cnt == 0 && new_pos < COLUMNS)) begin
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= new_pos;
        do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
        cfg_if.valid <= 1'b0;
        plan.position = new_pos;
      end

      gaps_on = ($urandom_range(0, 9) < 7);
      if (phase == 2) hold_off_req = 1'b1;

      if (phase == 0 || $urandom_range(0, 2) != 0) begin
        // well-formed: whole blocks, then their drain, with a little noise
        nblocks = (phase == 0) ? 2 : $urandom_range(1, 2);
        repeat (nblocks) begin
          n = BLOCK_WORDS - plan.wr_cnt;
          repeat (n) begin
            offer(KIND_WEIGHT, rand_word());
            if ($urandom_range(0, 19) == 0) offer(KIND_DRAIN, word_t'($urandom));
          end
        end
        repeat (nblocks * DRAIN_WORDS) begin
          offer(KIND_DRAIN, word_t'($urandom));
          if ($urandom_range(0, 19) == 0) offer(KIND_WEIGHT, rand_word());
        end
      end else begin
        // loose mix of weights and drains
        case ($urandom_range(0, 3))
          0:       drain_pct = 10;
          1:       drain_pct = 35;
          2:       drain_pct = 60;
          default: drain_pct = 90;
        endcase
        n = $urandom_range(80, 250);
        repeat (n) begin
          if ($urandom_range(0, 99) < drain_pct) offer(KIND_DRAIN, word_t'($urandom));
          else offer(KIND_WEIGHT, rand_word());
        end
      end
      phase++;
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("[systolic_weight_feeder_pingpong_unit] OK");
    end else begin
      $display("[systolic_weight_feeder_pingpong_unit] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
src/swf_pkg.sv
src/swf_if.sv
src/swf_bank.sv
src/swf_ctrl.sv
src/systolic_weight_feeder_pingpong_unit.sv
tb/sv/tb_systolic_weight_feeder_pingpong_unit.sv
